[rtl/core/wdt_pkg.sv]
// ============================================================================
// wdt_pkg
// Shared types and constants of the two-stage watchdog timer.
// ============================================================================
package wdt_pkg;

    // Widths of the bus fields
    localparam int DATA_W  = 32;
    localparam int ADDR_W  = 12;
    localparam int CMD_W   = 2;

    // Default counter width
    localparam int COUNT_WIDTH_DEF = 32;

    // Word that opens the lock
    localparam logic [DATA_W-1:0] LOCK_MAGIC = 32'h1ACC_E551;

    // Register byte offsets
    localparam logic [ADDR_W-1:0] OFF_LOAD   = 12'h000;
    localparam logic [ADDR_W-1:0] OFF_VALUE  = 12'h004;
    localparam logic [ADDR_W-1:0] OFF_CTRL   = 12'h008;
    localparam logic [ADDR_W-1:0] OFF_CLR    = 12'h00C;
    localparam logic [ADDR_W-1:0] OFF_RAW    = 12'h010;
    localparam logic [ADDR_W-1:0] OFF_MASKED = 12'h014;
    localparam logic [ADDR_W-1:0] OFF_LOCK   = 12'hC00;

    // Control register bit positions
    localparam int CTRL_INTEN_BIT = 0;
    localparam int CTRL_RESEN_BIT = 1;

    // Request kinds
    typedef enum logic [CMD_W-1:0] {
        CMD_TICK  = 2'd0,
        CMD_READ  = 2'd1,
        CMD_WRITE = 2'd2
    } cmd_t;

    // One request
    typedef struct packed {
        cmd_t              cmd;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] wdata;
    } wdt_req_t;

    // One response
    typedef struct packed {
        logic [DATA_W-1:0] rdata;
        logic              irq;
        logic              reset_out;
    } wdt_rsp_t;

endpackage

[rtl/core/wdt_core.sv]
// ============================================================================
// wdt_core
// Register file and down-counter of the watchdog; handles one request per
// enabled cycle and presents its response combinationally.
// ============================================================================
module wdt_core
    import wdt_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     fire,
    input  wdt_req_t req,
    output wdt_rsp_t rsp
);

    logic [COUNT_WIDTH-1:0] reload_reg, reload_next;
    logic [COUNT_WIDTH-1:0] count_reg, count_next;
    logic                   inten_reg, inten_next;
    logic                   resen_reg, resen_next;
    logic                   raw_reg, raw_next;
    logic                   locked_reg, locked_next;
    logic                   resout_reg, resout_next;
    logic [DATA_W-1:0]      rdata;

    // Compute the state after this request
    always_comb
    begin
        reload_next = reload_reg;
        count_next  = count_reg;
        inten_next  = inten_reg;
        resen_next  = resen_reg;
        raw_next    = raw_reg;
        locked_next = locked_reg;
        resout_next = resout_reg;
        case (req.cmd)
            CMD_TICK:
            begin
                if (inten_reg)
                begin
                    if (count_reg == '0)
                    begin
                        if (raw_reg && resen_reg)
                        begin
                            resout_next = 1'b1;
                        end
                        raw_next   = 1'b1;
                        count_next = reload_reg;
                    end
                    else
                    begin
                        count_next = count_reg - COUNT_WIDTH'(1);
                    end
                end
            end
            CMD_WRITE:
            begin
                if (req.addr == OFF_LOCK)
                begin
                    locked_next = (req.wdata != LOCK_MAGIC);
                end
                else if (!locked_reg)
                begin
                    case (req.addr)
                        OFF_LOAD:
                        begin
                            reload_next = req.wdata[COUNT_WIDTH-1:0];
                            count_next  = req.wdata[COUNT_WIDTH-1:0];
                        end
                        OFF_CTRL:
                        begin
                            // reload on a rising interrupt enable
                            if (req.wdata[CTRL_INTEN_BIT] && !inten_reg)
                            begin
                                count_next = reload_reg;
                            end
                            inten_next = req.wdata[CTRL_INTEN_BIT];
                            resen_next = req.wdata[CTRL_RESEN_BIT];
                        end
                        OFF_CLR:
                        begin
                            raw_next   = 1'b0;
                            count_next = reload_reg;
                        end
                        default:
                        begin
                            raw_next = raw_reg;
                        end
                    endcase
                end
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    // Read mux over the state before this request
    always_comb
    begin
        rdata = '0;
        if (req.cmd == CMD_READ)
        begin
            case (req.addr)
                OFF_LOAD:   rdata = DATA_W'(reload_reg);
                OFF_VALUE:  rdata = DATA_W'(count_reg);
                OFF_CTRL:   rdata = DATA_W'({resen_reg, inten_reg});
                OFF_RAW:    rdata = DATA_W'(raw_reg);
                OFF_MASKED: rdata = DATA_W'(raw_reg & inten_reg);
                OFF_LOCK:   rdata = DATA_W'(locked_reg);
                default:    rdata = '0;
            endcase
        end
    end

    assign rsp.rdata     = rdata;
    assign rsp.irq       = raw_next & inten_next;
    assign rsp.reset_out = resout_next;

    // Advance the state on each processed request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reload_reg <= '1;
            count_reg  <= '1;
            inten_reg  <= 1'b0;
            resen_reg  <= 1'b0;
            raw_reg    <= 1'b0;
            locked_reg <= 1'b0;
            resout_reg <= 1'b0;
        end
        else if (fire)
        begin
            reload_reg <= reload_next;
            count_reg  <= count_next;
            inten_reg  <= inten_next;
            resen_reg  <= resen_next;
            raw_reg    <= raw_next;
            locked_reg <= locked_next;
            resout_reg <= resout_next;
        end
    end

endmodule

[rtl/core/watchdog_timer_registers_top.sv]
// ============================================================================
// watchdog_timer_registers_top: two-stage watchdog with lock register
// A request passes through the input register, then the response register.
// Throughput: one request per cycle unless m_tready stalls the response side,
// set by the counter and register update. Reset clears all control state,
// loads the counter and load register with all ones and leaves it unlocked.
// ============================================================================
module watchdog_timer_registers_top
    import wdt_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // [11:0] addr, [43:12] wdata, [47:44] zero
    input  logic [1:0]  s_tuser,   // [1:0] cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // [31:0] rdata, [32] irq, [33] reset_out, rest zero
);

    logic     in_valid_reg, in_valid_next;
    wdt_req_t in_req_reg, in_req_next;
    logic     out_valid_reg, out_valid_next;
    wdt_rsp_t out_rsp_reg, out_rsp_next;
    wdt_rsp_t core_rsp;
    logic     advance;
    logic     fire;

    // Hand-off between the input and response registers
    assign advance  = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    // Capture a new request when the input register frees up
    always_comb
    begin
        in_valid_next       = in_valid_reg;
        in_req_next         = in_req_reg;
        if (s_tready)
        begin
            in_valid_next     = s_tvalid;
            in_req_next.cmd   = cmd_t'(s_tuser);
            in_req_next.addr  = s_tdata[ADDR_W-1:0];
            in_req_next.wdata = s_tdata[ADDR_W+DATA_W-1:ADDR_W];
        end
    end

    // Load the response register when the downstream side moves
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_rsp_next   = out_rsp_reg;
        if (advance)
        begin
            out_valid_next = in_valid_reg;
            out_rsp_next   = core_rsp;
        end
    end

    wdt_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .req   (in_req_reg),
        .rsp   (core_rsp)
    );

    // Valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        in_req_reg  <= in_req_next;
        out_rsp_reg <= out_rsp_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, out_rsp_reg.reset_out, out_rsp_reg.irq, out_rsp_reg.rdata};

endmodule

[test/wdt_checker.sv]
`timescale 1ns / 100ps
// ============================================================================
// wdt_checker
// Watches both stream channels of the watchdog. Each request taken on the
// slave side is run through an independent model of the counter, status
// and lock logic. The resulting response is queued. Each response taken on
// the master side is compared field by field with the oldest queued one.
// ============================================================================
module wdt_checker
    import wdt_pkg::*;
#(
    parameter int COUNT_W = COUNT_WIDTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [47:0] s_tdata,   // [11:0] addr, [43:12] wdata, [47:44] zero
    input  logic [1:0]  s_tuser,   // [1:0] cmd
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [39:0] m_tdata,   // [31:0] rdata, [32] irq, [33] reset_out
    output int          fail_count,
    output int          rsp_waiting
);

    // Model state of the watchdog
    logic [COUNT_W-1:0] wd_reload;
    logic [COUNT_W-1:0] wd_count;
    logic               wd_int_en;
    logic               wd_res_en;
    logic               wd_raw;
    logic               wd_locked;
    logic               wd_reset_req;

    wdt_rsp_t pending_rsp_q[$];
    int       mismatch_total;

    // Apply one request to the model and return the response it causes
    function automatic wdt_rsp_t step_watchdog(input logic [CMD_W-1:0] cmd,
                                               input logic [ADDR_W-1:0] addr,
                                               input logic [DATA_W-1:0] wdata);
        wdt_rsp_t rsp;
        logic     new_ie;
        rsp = '0;
        case (cmd)
            CMD_TICK:
                if (wd_int_en) begin
                    if (wd_count == '0) begin
                        // second zero with the interrupt still pending
                        if (wd_raw && wd_res_en)
                            wd_reset_req = 1'b1;
                        wd_raw   = 1'b1;
                        wd_count = wd_reload;
                    end
                    else begin
                        wd_count = wd_count - COUNT_W'(1);
                    end
                end
            CMD_READ:
                case (addr)
                    OFF_LOAD:   rsp.rdata = DATA_W'(wd_reload);
                    OFF_VALUE:  rsp.rdata = DATA_W'(wd_count);
                    OFF_CTRL:   rsp.rdata = DATA_W'({wd_res_en, wd_int_en});
                    OFF_RAW:    rsp.rdata = DATA_W'(wd_raw);
                    OFF_MASKED: rsp.rdata = DATA_W'(wd_raw & wd_int_en);
                    OFF_LOCK:   rsp.rdata = DATA_W'(wd_locked);
                    default:    rsp.rdata = '0;
                endcase
            CMD_WRITE:
                if (addr == OFF_LOCK) begin
                    wd_locked = (wdata != LOCK_MAGIC);
                end
                else if (!wd_locked) begin
                    case (addr)
                        OFF_LOAD: begin
                            wd_reload = wdata[COUNT_W-1:0];
                            wd_count  = wdata[COUNT_W-1:0];
                        end
                        OFF_CTRL: begin
                            new_ie = wdata[CTRL_INTEN_BIT];
                            // enabling reloads the counter
                            if (new_ie && !wd_int_en)
                                wd_count = wd_reload;
                            wd_int_en = new_ie;
                            wd_res_en = wdata[CTRL_RESEN_BIT];
                        end
                        OFF_CLR: begin
                            wd_raw   = 1'b0;
                            wd_count = wd_reload;
                        end
                        default: ;
                    endcase
                end
            default: ;
        endcase
        rsp.irq       = wd_raw & wd_int_en;
        rsp.reset_out = wd_reset_req;
        return rsp;
    endfunction

    // Track requests and check responses
    always @(posedge clk or negedge rst_n)
    begin
        wdt_rsp_t want;
        wdt_rsp_t got;
        if (!rst_n) begin
            wd_reload      = '1;
            wd_count       = '1;
            wd_int_en      = 1'b0;
            wd_res_en      = 1'b0;
            wd_raw         = 1'b0;
            wd_locked      = 1'b0;
            wd_reset_req   = 1'b0;
            mismatch_total = 0;
            pending_rsp_q.delete();
            fail_count  <= 0;
            rsp_waiting <= 0;
        end
        else begin
            // model each accepted request
            if (s_tvalid && s_tready)
                pending_rsp_q.push_back(step_watchdog(s_tuser, s_tdata[11:0],
                                                      s_tdata[43:12]));
            // compare each accepted response with the oldest prediction
            if (m_tvalid && m_tready) begin
                got.rdata     = m_tdata[31:0];
                got.irq       = m_tdata[32];
                got.reset_out = m_tdata[33];
                if (pending_rsp_q.size() == 0) begin
                    mismatch_total++;
                    if (mismatch_total <= 10)
                        $display("%0t: unexpected response rdata=%h irq=%b rst=%b",
                                 $realtime, got.rdata, got.irq, got.reset_out);
                end
                else begin
                    want = pending_rsp_q.pop_front();
                    if (got.rdata !== want.rdata || got.irq !== want.irq
                        || got.reset_out !== want.reset_out) begin
                        mismatch_total++;
                        if (mismatch_total <= 10)
                            $display("%0t: exp rdata=%h irq=%b rst=%b, act rdata=%h irq=%b rst=%b",
                                     $realtime,
                                     want.rdata, want.irq, want.reset_out,
                                     got.rdata, got.irq, got.reset_out);
                    end
                end
            end
            fail_count  <= mismatch_total;
            rsp_waiting <= pending_rsp_q.size();
        end
    end

endmodule

[test/tb_top.sv]
`timescale 1ns / 100ps
// ============================================================================
// tb_top
// Drives ticks, register reads and register writes into the watchdog with
// random gaps and output stalls: a directed opening, then mostly unlock,
// load, enable and countdown sequences mixed with stray accesses. The
// checker predicts and compares every response; this module gives the verdict.
// ============================================================================
module tb_top;
    import wdt_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED  = 2'd3;
    localparam int               ITEM_TARGET = 1000;
    localparam int               CYCLE_LIMIT = 400000;
    localparam int               DRAIN_LIMIT = 5000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;    // [11:0] addr, [43:12] wdata, [47:44] zero
    logic [1:0]  s_tuser = '0;    // [1:0] cmd
    logic        m_tvalid;
    logic        m_tready = 1'b1;
    logic [39:0] m_tdata;         // [31:0] rdata, [32] irq, [33] reset_out
    int          fail_count;
    int          rsp_waiting;
    int          cycle_count = 0;
    int          items_sent = 0;
    int          sink_hold = 0;
    bit          quiet_phase = 1'b0;

    // Clock generation
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    watchdog_timer_registers_top i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    wdt_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .fail_count  (fail_count),
        .rsp_waiting (rsp_waiting)
    );

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Mostly short idle stretches, a few long ones, none in quiet phases
    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet_phase || r < 70)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Stall the response side at random
    always @(posedge clk)
    begin
        int gap;
        if (sink_hold > 0) begin
            sink_hold = sink_hold - 1;
            m_tready <= (sink_hold == 0);
        end
        else begin
            gap = draw_gap();
            sink_hold = gap;
            m_tready <= (gap == 0);
        end
    end

    // Issue one request and hold it until accepted
    task automatic send_request(input logic [CMD_W-1:0] cmd,
                                input logic [ADDR_W-1:0] addr,
                                input logic [DATA_W-1:0] wdata);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, wdata, addr};
        s_tuser  <= cmd;
        do
            @(posedge clk);
        while (!s_tready);
        items_sent++;
    endtask

    function automatic logic [ADDR_W-1:0] pick_reg();
        case ($urandom_range(0, 6))
            0:       return OFF_LOAD;
            1:       return OFF_VALUE;
            2:       return OFF_CTRL;
            3:       return OFF_CLR;
            4:       return OFF_RAW;
            5:       return OFF_MASKED;
            default: return OFF_LOCK;
        endcase
    endfunction

    // Unlock, load, enable and let the counter run down
    task automatic run_countdown();
        int          n_ticks;
        int          r;
        logic [31:0] ctrl;
        send_request(CMD_WRITE, OFF_LOCK, LOCK_MAGIC);
        r = $urandom_range(0, 99);
        if (r < 80)
            send_request(CMD_WRITE, OFF_LOAD, $urandom_range(0, 6));
        else if (r < 95)
            send_request(CMD_WRITE, OFF_LOAD, $urandom & 32'hFF);
        else
            send_request(CMD_WRITE, OFF_LOAD, $urandom);
        ctrl = $urandom;
        if ($urandom_range(0, 99) < 85)
            ctrl[CTRL_INTEN_BIT] = 1'b1;
        send_request(CMD_WRITE, OFF_CTRL, ctrl);
        n_ticks = $urandom_range(1, 20);
        repeat (n_ticks) begin
            r = $urandom_range(0, 99);
            if (r < 70)
                send_request(CMD_TICK, ADDR_W'($urandom), $urandom);
            else if (r < 90)
                send_request(CMD_READ, pick_reg(), $urandom);
            else if (r < 95)
                send_request(CMD_WRITE, OFF_CLR, $urandom);
            else
                send_request(CMD_WRITE, OFF_CTRL, $urandom);
        end
        // close the lock now and then
        if ($urandom_range(0, 99) < 40)
            send_request(CMD_WRITE, OFF_LOCK, $urandom);
    endtask

    // Stimulus
    initial
    begin
        int r;
        int drain;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // read every register out of reset
        send_request(CMD_READ, OFF_LOAD, '0);
        send_request(CMD_READ, OFF_VALUE, '0);
        send_request(CMD_READ, OFF_CTRL, '0);
        send_request(CMD_READ, OFF_CLR, '0);
        send_request(CMD_READ, OFF_RAW, '0);
        send_request(CMD_READ, OFF_MASKED, '0);
        send_request(CMD_READ, OFF_LOCK, '0);
        // locked: the load write must be dropped
        send_request(CMD_WRITE, OFF_LOCK, '0);
        send_request(CMD_WRITE, OFF_LOAD, 32'h0000_0005);
        send_request(CMD_READ, OFF_LOAD, '1);
        // reopen, load zero, enable interrupt and reset
        send_request(CMD_WRITE, OFF_LOCK, LOCK_MAGIC);
        send_request(CMD_WRITE, OFF_LOAD, '0);
        send_request(CMD_WRITE, OFF_CTRL, 32'h0000_0003);
        send_request(CMD_TICK, '1, '1);
        send_request(CMD_READ, OFF_MASKED, '0);
        send_request(CMD_TICK, '0, '0);
        send_request(CMD_WRITE, OFF_CLR, '1);
        // unaligned, unmapped, unused command, read-only register
        send_request(CMD_WRITE, 12'h002, '1);
        send_request(CMD_READ, 12'hFFF, '0);
        send_request(CMD_UNUSED, OFF_LOAD, '1);
        send_request(CMD_WRITE, OFF_VALUE, 32'h1234_5678);
        // full-scale load, then disable and tick
        send_request(CMD_WRITE, OFF_LOAD, '1);
        send_request(CMD_READ, OFF_VALUE, '0);
        send_request(CMD_WRITE, OFF_CTRL, '0);
        send_request(CMD_TICK, '0, '0);

        // random part
        while (items_sent < ITEM_TARGET) begin
            if ($urandom_range(0, 9) == 0)
                quiet_phase = ~quiet_phase;
            r = $urandom_range(0, 99);
            if (r < 60)
                run_countdown();
            else if (r < 85)
                send_request(CMD_W'($urandom_range(0, 2)), pick_reg(), $urandom);
            else
                send_request(CMD_W'($urandom), ADDR_W'($urandom), $urandom);
        end
        s_tvalid <= 1'b0;
        quiet_phase = 1'b0;

        // let the checker count the last request before draining
        @(posedge clk);

        // drain outstanding responses
        drain = 0;
        while (rsp_waiting != 0 && drain < DRAIN_LIMIT) begin
            @(posedge clk);
            drain++;
        end
        repeat (10) @(posedge clk);
        if (fail_count == 0 && rsp_waiting == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

[watchdog_timer_registers_top.f]
rtl/core/wdt_pkg.sv
rtl/core/wdt_core.sv
rtl/core/watchdog_timer_registers_top.sv
test/wdt_checker.sv
test/tb_top.sv
